[sv/srsg_pkg.sv]
// Shared types, constants and tables for the spinning ring span generator.
// No dependencies; every other file imports this package.
`default_nettype none

package srsg_pkg;

  // Angle resolution of the input index (one turn)
  localparam int ANGLE_STEPS = 64;

  // Bit-serial root: radicand below 2**14, so the root has 7 bits
  localparam int RAD_W      = 14;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS + 1);

  // Configuration register indexes
  localparam logic [3:0] REG_CENTER_X     = 4'd0;
  localparam logic [3:0] REG_CENTER_Y     = 4'd1;
  localparam logic [3:0] REG_OUTER_RADIUS = 4'd2;
  localparam logic [3:0] REG_INNER_RADIUS = 4'd3;
  localparam logic [3:0] REG_COLOR_TOP    = 4'd4;
  localparam logic [3:0] REG_COLOR_UPPER  = 4'd5;
  localparam logic [3:0] REG_COLOR_MIDDLE = 4'd6;
  localparam logic [3:0] REG_COLOR_BOTTOM = 4'd7;

  typedef struct packed {
    logic [8:0] center_x;
    logic [7:0] center_y;
    logic [6:0] outer_radius;
    logic [6:0] inner_radius;
    logic [7:0] color_top;
    logic [7:0] color_upper;
    logic [7:0] color_middle;
    logic [7:0] color_bottom;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SETUP,
    S_ROOT,
    S_MULT,
    S_DIV,
    S_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic prep;
    logic setup;
    logic root_step;
    logic mult;
    logic div;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic int sine_val(input int t);
    int s;
    begin
      unique case (t % 32)
        0:  s = 0;    1:  s = 12;   2:  s = 25;   3:  s = 37;
        4:  s = 49;   5:  s = 60;   6:  s = 71;   7:  s = 81;
        8:  s = 90;   9:  s = 98;   10: s = 106;  11: s = 112;
        12: s = 117;  13: s = 122;  14: s = 125;  15: s = 127;
        16: s = 127;  17: s = 127;  18: s = 125;  19: s = 122;
        20: s = 117;  21: s = 112;  22: s = 106;  23: s = 98;
        24: s = 90;   25: s = 81;   26: s = 71;   27: s = 60;
        28: s = 49;   29: s = 37;   30: s = 25;   default: s = 12;
      endcase
      // second half of the table is the negated first half
      return (t >= 32) ? -s : s;
    end
  endfunction

  typedef logic [6:0] cos_tab_t [64];

  // |cos| for every 6-bit angle index, built at elaboration
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    int k;
    int t;
    int s;
    begin
      for (int a = 0; a < 64; a++) begin
        k = (a + ANGLE_STEPS / 4) % ANGLE_STEPS;
        t = ((k * 64) / ANGLE_STEPS) % 64;
        s = sine_val(t);
        if (s < 0) s = -s;
        tab[a] = 7'(s);
      end
      return tab;
    end
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

`default_nettype wire

[sv/srsg_cfg.sv]
// Configuration register bank for the span generator.
// Depends on srsg_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module srsg_cfg
  import srsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  output cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x     <= 9'd160;
      cfg.center_y     <= 8'd110;
      cfg.outer_radius <= 7'd44;
      cfg.inner_radius <= 7'd27;
      cfg.color_top    <= 8'd244;
      cfg.color_upper  <= 8'd243;
      cfg.color_middle <= 8'd242;
      cfg.color_bottom <= 8'd241;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X:     cfg.center_x     <= cfg_data;
        REG_CENTER_Y:     cfg.center_y     <= cfg_data[7:0];
        REG_OUTER_RADIUS: cfg.outer_radius <= cfg_data[6:0];
        REG_INNER_RADIUS: cfg.inner_radius <= cfg_data[6:0];
        REG_COLOR_TOP:    cfg.color_top    <= cfg_data[7:0];
        REG_COLOR_UPPER:  cfg.color_upper  <= cfg_data[7:0];
        REG_COLOR_MIDDLE: cfg.color_middle <= cfg_data[7:0];
        REG_COLOR_BOTTOM: cfg.color_bottom <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/srsg_ctrl.sv]
// Sequencing state machine for the span generator.
// Depends on srsg_pkg for state, command and status types.
`default_nettype none

module srsg_ctrl
  import srsg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output cmd_t      cmd,
  input  sts_t      sts
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        step_next  = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == STEP_W'(ROOT_STEPS - 1)) state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sv/srsg_dp.sv]
// Datapath: radius squares, two bit-serial square roots, scale by |cos|/127,
// span and colour assembly, and the output register. Depends on srsg_pkg.
`default_nettype none

module srsg_dp
  import srsg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  cfg_t                   cfg,
  input  wire logic [5:0]        angle_index,
  input  wire logic signed [7:0] row_offset,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   row_present,
  output logic signed [9:0]      row_y,
  output logic signed [9:0]      left_first,
  output logic signed [9:0]      left_last,
  output logic signed [9:0]      right_first,
  output logic signed [9:0]      right_last,
  output logic                   center_dot,
  output logic [7:0]             color
);

  logic signed [7:0] dy;
  logic [6:0]        w;
  logic [7:0]        ady;
  logic [14:0]       dy2;
  logic [13:0]       ro2, ri2;
  logic [6:0]        th_hi, th_lo;
  logic              present;
  logic [RAD_W-1:0]  v_o, v_i, root_o, root_i, bitv;
  logic [13:0]       prod_o, prod_i;
  logic [6:0]        xo, xi;

  logic [7:0]        ady_c;
  logic [15:0]       th_hi_m, th_lo_m;
  logic [RAD_W:0]    try_o, try_i;
  logic [7:0]        rem_o, rem_i, q_o, q_i;
  logic [9:0]        cx10;
  logic signed [8:0] dy9, neg_hi, neg_lo, pos_lo;
  logic [7:0]        col_c;

  assign ady_c   = dy[7] ? 8'(-dy) : 8'(dy);
  assign th_hi_m = {7'd0, cfg.outer_radius, 1'b0} * 16'd171;  // (2r)/3
  assign th_lo_m = {9'd0, cfg.outer_radius} * 16'd171;        // r/3

  assign try_o = {1'b0, root_o} + {1'b0, bitv};
  assign try_i = {1'b0, root_i} + {1'b0, bitv};

  // divide by 127: floor(p/128) is at most one short
  assign rem_o = {1'b0, prod_o[6:0]} + {1'b0, prod_o[13:7]};
  assign rem_i = {1'b0, prod_i[6:0]} + {1'b0, prod_i[13:7]};
  assign q_o   = {1'b0, prod_o[13:7]} + {7'd0, (rem_o >= 8'd127)};
  assign q_i   = {1'b0, prod_i[13:7]} + {7'd0, (rem_i >= 8'd127)};

  assign cx10   = {1'b0, cfg.center_x};
  assign dy9    = {dy[7], dy};
  assign neg_hi = 9'sd0 - $signed({2'b0, th_hi});
  assign neg_lo = 9'sd0 - $signed({2'b0, th_lo});
  assign pos_lo = $signed({2'b0, th_lo});

  always_comb begin
    if (dy9 < neg_hi)      col_c = cfg.color_top;
    else if (dy9 < neg_lo) col_c = cfg.color_upper;
    else if (dy9 < pos_lo) col_c = cfg.color_middle;
    else                   col_c = cfg.color_bottom;
  end

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dy <= row_offset;
      w  <= COS_TAB[angle_index];
    end
    if (cmd.prep) begin
      ady   <= ady_c;
      dy2   <= 15'(ady_c * ady_c);
      ro2   <= cfg.outer_radius * cfg.outer_radius;
      ri2   <= cfg.inner_radius * cfg.inner_radius;
      th_hi <= th_hi_m[15:9];
      th_lo <= th_lo_m[15:9];
    end
    if (cmd.setup) begin
      present <= (ady <= {1'b0, cfg.outer_radius});
      v_o     <= ({1'b0, ro2} >= dy2) ? RAD_W'({1'b0, ro2} - dy2) : '0;
      v_i     <= ({1'b0, ri2} >= dy2) ? RAD_W'({1'b0, ri2} - dy2) : '0;
      root_o  <= '0;
      root_i  <= '0;
      bitv    <= RAD_W'(1) << (RAD_W - 2);
    end
    if (cmd.root_step) begin
      if ({1'b0, v_o} >= try_o) begin
        v_o    <= RAD_W'({1'b0, v_o} - try_o);
        root_o <= (root_o >> 1) + bitv;
      end else begin
        root_o <= root_o >> 1;
      end
      if ({1'b0, v_i} >= try_i) begin
        v_i    <= RAD_W'({1'b0, v_i} - try_i);
        root_i <= (root_i >> 1) + bitv;
      end else begin
        root_i <= root_i >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (cmd.mult) begin
      prod_o <= w * root_o[6:0];
      prod_i <= w * root_i[6:0];
    end
    if (cmd.div) begin
      xo <= q_o[6:0];
      // clamp the hole to the outer half-width
      xi <= (q_i[6:0] > q_o[6:0]) ? q_o[6:0] : q_i[6:0];
    end
    if (cmd.finish) begin
      row_y <= $signed(10'({2'b0, cfg.center_y}) + {{2{dy[7]}}, dy});
      row_present <= present;
      if (present) begin
        left_first  <= $signed(cx10 - {3'd0, xo});
        left_last   <= $signed(cx10 - {3'd0, xi} - 10'd1);
        right_first <= $signed(cx10 + {3'd0, xi} + 10'd1);
        right_last  <= $signed(cx10 + {3'd0, xo});
        center_dot  <= (xo != 7'd0) && (xi == 7'd0);
        color       <= col_c;
      end else begin
        left_first  <= '0;
        left_last   <= '0;
        right_first <= '0;
        right_last  <= '0;
        center_dot  <= 1'b0;
        color       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[sv/spinning_ring_span_generator.sv]
// Spinning ring span generator, top level.
// Each row goes through capture, squares, setup, seven root steps, scale,
// divide and finish; a new row is accepted only after the last one finishes,
// and finish waits while a previous result is still stalled in the output.
// A finished result waits in the output register while the next row starts.
// Reset (rst, synchronous): controller idle, output empty, registers at
// center 160,110, radii 44/27, colors 244/243/242/241.
`default_nettype none

module spinning_ring_span_generator
  import srsg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [3:0]        cfg_index,
  input  wire logic [8:0]        cfg_data,
  // input item channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [5:0]        angle_index,
  input  wire logic signed [7:0] row_offset,
  // result item channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   row_present,
  output logic signed [9:0]      row_y,
  output logic signed [9:0]      left_first,
  output logic signed [9:0]      left_last,
  output logic signed [9:0]      right_first,
  output logic signed [9:0]      right_last,
  output logic                   center_dot,
  output logic [7:0]             color
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Register bank; write it only while no item is in flight
  srsg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: capture, squares, setup, root steps, scale, divide, finish
  srsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Arithmetic and output register
  srsg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .angle_index (angle_index),
    .row_offset  (row_offset),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .row_present (row_present),
    .row_y       (row_y),
    .left_first  (left_first),
    .left_last   (left_last),
    .right_first (right_first),
    .right_last  (right_last),
    .center_dot  (center_dot),
    .color       (color)
  );

endmodule

`default_nettype wire
